// File: rtl/ltrf_pkg.sv
// ----------------------------------------------------------------------------
// ltrf_pkg : shared types and constants of the LCD readout formatter
// Image geometry, controller words, glyph table and the job passed between
// the front classifier and the back emitter.
// ----------------------------------------------------------------------------
package ltrf_pkg;

   localparam int IMAGE_NIBBLES = 19;
   localparam int NIB_IDX_W     = $clog2(IMAGE_NIBBLES);
   localparam int LINES         = 3;
   localparam int DIGITS        = 3;
   localparam int DIG_IDX_W     = $clog2(DIGITS);

   localparam int REQ_TDATA_W   = 24;
   localparam int REQ_TUSER_W   = 3;
   localparam int RSP_TDATA_W   = 16;

   localparam int VALUE_W       = 20;
   localparam int X_W           = VALUE_W + 1;
   localparam int RECIP_W       = 20;
   localparam int RECIP_SHIFT   = 23;
   localparam int QUOT_W        = X_W + RECIP_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 20'hCCCCD;

   localparam logic [VALUE_W-1:0] LIMIT_HUNDREDTHS = 20'd10000;
   localparam logic [VALUE_W-1:0] LIMIT_TENTHS     = 20'd100000;

   localparam int WORD_W        = 12;
   localparam int BITW_W        = 4;

   localparam logic [WORD_W-1:0] CMD_SYS_EN   = 12'h802;
   localparam logic [WORD_W-1:0] CMD_LCD_ON   = 12'h806;
   localparam logic [WORD_W-1:0] CMD_BIAS     = 12'h852;
   localparam logic [WORD_W-1:0] WRITE_HEADER = 12'h140;

   localparam logic [BITW_W-1:0] WIDTH_CMD    = 4'd12;
   localparam logic [BITW_W-1:0] WIDTH_HEADER = 4'd9;
   localparam logic [BITW_W-1:0] WIDTH_NIBBLE = 4'd4;

   localparam logic       OP_INIT   = 1'b0;
   localparam logic [1:0] LINE_NONE = 2'd3;

   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {FR_IDLE, FR_SCALE, FR_DIGIT, FR_PUSH} front_state_type;
   typedef enum logic [1:0] {BK_IDLE, BK_CMD, BK_HEADER, BK_NIBBLE} back_state_type;

   typedef struct packed {
      logic                   init;
      logic [1:0]             line;
      logic [1:0]             marks;
      logic [DIGITS-1:0][3:0] digits;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [6:0] glyph(input logic [3:0] digit);
      logic [6:0] g;
      case (digit)
         4'd0:    g = 7'h3F;
         4'd1:    g = 7'h06;
         4'd2:    g = 7'h5B;
         4'd3:    g = 7'h4F;
         4'd4:    g = 7'h66;
         4'd5:    g = 7'h6D;
         4'd6:    g = 7'h7D;
         4'd7:    g = 7'h07;
         4'd8:    g = 7'h7F;
         4'd9:    g = 7'h6F;
         default: g = 7'h00;
      endcase
      return g;
   endfunction

   function automatic logic [WORD_W-1:0] init_command(input logic [1:0] idx);
      logic [WORD_W-1:0] w;
      case (idx)
         2'd0:    w = CMD_SYS_EN;
         2'd1:    w = CMD_LCD_ON;
         2'd2:    w = CMD_BIAS;
         default: w = CMD_SYS_EN;
      endcase
      return w;
   endfunction

endpackage

// File: rtl/lcd_triple_readout_formatter.sv
// ----------------------------------------------------------------------------
// lcd_triple_readout_formatter : three-line segment LCD readout formatter
// The emitter sends one serial word a cycle while the result side is ready;
// the digit unit overlaps with emission.
// Reset: synchronous, clears the segment image, queue and output valid flag.
// ----------------------------------------------------------------------------
module lcd_triple_readout_formatter
   import ltrf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // value_milli
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // operation, line
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // word, bit_width
   output logic                   rsp_tuser,   // frame_end
   output logic                   rsp_tlast
);

   queue_status_type status;
   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          pop_job;

   ltrf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .push       (push),
      .push_job   (push_job)
   );

   ltrf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (status)
   );

   ltrf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_job    (pop_job),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/ltrf_front.sv
// ----------------------------------------------------------------------------
// ltrf_front : item classifier and decimal digit unit
// Takes items, picks the rounding range, scales by tens and splits off three
// digits with one reciprocal multiply a cycle, then queues a job.
// ----------------------------------------------------------------------------
module ltrf_front
   import ltrf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // value_milli
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // operation, line
   input  queue_status_type       status,
   output logic                   push,
   output job_type                push_job
);

   front_state_type              state_ff, state_in;
   logic [X_W-1:0]               x_ff, x_in;
   logic [1:0]                   steps_ff, steps_in;
   logic [DIG_IDX_W-1:0]         idx_ff, idx_in;
   logic [DIGITS-1:0][3:0]       digits_ff, digits_in;
   logic                         init_ff, init_in;
   logic [1:0]                   line_ff, line_in;
   logic [1:0]                   marks_ff, marks_in;

   logic                         accept;
   logic                         operation;
   logic [1:0]                   line;
   logic [VALUE_W-1:0]           value_milli;
   logic [X_W+RECIP_W-1:0]       prod;
   logic [X_W-1:0]               quot;
   logic [X_W-1:0]               times10;
   logic [X_W-1:0]               diff;
   logic [3:0]                   rem;

   assign operation   = req_tuser[0];
   assign line        = req_tuser[2:1];
   assign value_milli = req_tdata[VALUE_W-1:0];
   assign req_tready  = (state_ff == FR_IDLE);
   assign accept      = req_tvalid & req_tready;

   assign prod    = {{RECIP_W{1'b0}}, x_ff} * {{X_W{1'b0}}, RECIP_TEN};
   assign quot    = X_W'(prod[RECIP_SHIFT +: QUOT_W]);
   assign times10 = (quot << 3) + (quot << 1);
   assign diff    = x_ff - times10;
   assign rem     = diff[3:0];

   assign push_job = '{init: init_ff, line: line_ff, marks: marks_ff, digits: digits_ff};

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      steps_in  = steps_ff;
      idx_in    = idx_ff;
      digits_in = digits_ff;
      init_in   = init_ff;
      line_in   = line_ff;
      marks_in  = marks_ff;
      push      = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            if (accept) begin
               init_in = (operation == OP_INIT);
               line_in = line;
               if (operation == OP_INIT) begin
                  state_in = FR_PUSH;
               end else if (line != LINE_NONE) begin
                  state_in = FR_SCALE;
                  if (value_milli < LIMIT_HUNDREDTHS) begin
                     x_in     = X_W'(value_milli) + X_W'(5);
                     steps_in = 2'd1;
                     marks_in = 2'b10;
                  end else if (value_milli < LIMIT_TENTHS) begin
                     x_in     = X_W'(value_milli) + X_W'(50);
                     steps_in = 2'd2;
                     marks_in = 2'b01;
                  end else begin
                     x_in     = X_W'(value_milli) + X_W'(500);
                     steps_in = 2'd3;
                     marks_in = 2'b00;
                  end
               end
            end
         end
         FR_SCALE: begin
            x_in     = quot;
            steps_in = steps_ff - 2'd1;
            if (steps_ff == 2'd1) begin
               state_in = FR_DIGIT;
               idx_in   = '0;
            end
         end
         FR_DIGIT: begin
            digits_in[idx_ff] = rem;
            x_in              = quot;
            if (idx_ff == DIG_IDX_W'(DIGITS-1)) begin
               state_in = FR_PUSH;
            end else begin
               idx_in = idx_ff + DIG_IDX_W'(1);
            end
         end
         FR_PUSH: begin
            if (!status.full) begin
               push     = 1'b1;
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      steps_ff  <= steps_in;
      idx_ff    <= idx_in;
      digits_ff <= digits_in;
      init_ff   <= init_in;
      line_ff   <= line_in;
      marks_ff  <= marks_in;
   end

endmodule

// File: rtl/ltrf_queue.sv
// ----------------------------------------------------------------------------
// ltrf_queue : short job queue between classifier and emitter
// Holds decoded jobs so that each side stalls on its own.
// ----------------------------------------------------------------------------
module ltrf_queue
   import ltrf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          pop_job,
   output queue_status_type status
);

   job_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_job      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty) else $error("pop from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue count overrun");

endmodule

// File: rtl/ltrf_back.sv
// ----------------------------------------------------------------------------
// ltrf_back : segment image and serial word emitter
// Applies a job to the segment image, then streams an init job's commands, the
// write header and every image nibble, one word a cycle when not stalled.
// ----------------------------------------------------------------------------
module ltrf_back
   import ltrf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  job_type                pop_job,
   input  queue_status_type       status,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // word, bit_width
   output logic                   rsp_tuser,   // frame_end
   output logic                   rsp_tlast
);

   back_state_type          state_ff, state_in;
   logic [NIB_IDX_W-1:0]    count_ff, count_in;
   logic [3:0]              image_ff [IMAGE_NIBBLES];
   logic [3:0]              image_in [IMAGE_NIBBLES];
   logic                    valid_ff, valid_in;
   logic [WORD_W-1:0]       word_ff, word_in;
   logic [BITW_W-1:0]       width_ff, width_in;
   logic                    fend_ff, fend_in;
   logic                    last_ff, last_in;

   logic                    load;
   logic                    nib_end;
   logic [NIB_IDX_W-1:0]    base;
   logic [NIB_IDX_W-1:0]    lo_pos [DIGITS];
   logic [NIB_IDX_W-1:0]    hi_pos [DIGITS];
   logic [6:0]              g [DIGITS];
   logic [DIGITS-1:0]       mark_sel;

   assign load     = !valid_ff || rsp_tready;
   assign nib_end  = (count_ff == NIB_IDX_W'(IMAGE_NIBBLES-1));
   assign base     = NIB_IDX_W'({pop_job.line, 2'b00}) + NIB_IDX_W'({pop_job.line, 1'b0})
                     + NIB_IDX_W'(1);
   assign mark_sel = {pop_job.marks, 1'b0};

   always_comb begin
      for (int j = 0; j < DIGITS; j++) begin
         lo_pos[j] = base + NIB_IDX_W'(2*j);
         hi_pos[j] = base + NIB_IDX_W'(2*j+1);
         g[j]      = glyph(pop_job.digits[j]);
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      valid_in = valid_ff;
      word_in  = word_ff;
      width_in = width_ff;
      fend_in  = fend_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      for (int n = 0; n < IMAGE_NIBBLES; n++) begin
         image_in[n] = image_ff[n];
      end
      case (state_ff)
         BK_IDLE: begin
            if (load) begin
               valid_in = 1'b0;
            end
            if (!status.empty) begin
               pop      = 1'b1;
               count_in = '0;
               if (pop_job.init) begin
                  state_in = BK_CMD;
                  for (int n = 0; n < IMAGE_NIBBLES; n++) begin
                     image_in[n] = 4'h0;
                     for (int k = 0; k < LINES; k++) begin
                        if (n == 2*DIGITS*k+1) begin
                           image_in[n] = 4'h8;
                        end
                     end
                  end
               end else begin
                  state_in = BK_HEADER;
                  for (int n = 0; n < IMAGE_NIBBLES; n++) begin
                     for (int j = 0; j < DIGITS; j++) begin
                        if (NIB_IDX_W'(n) == lo_pos[j]) begin
                           image_in[n] = {(j == 0) ? image_ff[n][3] : mark_sel[j],
                                          g[j][2], g[j][6], g[j][1]};
                        end
                        if (NIB_IDX_W'(n) == hi_pos[j]) begin
                           image_in[n] = {g[j][3], g[j][4], g[j][5], g[j][0]};
                        end
                     end
                  end
               end
            end
         end
         BK_CMD: begin
            if (load) begin
               valid_in = 1'b1;
               word_in  = init_command(count_ff[1:0]);
               width_in = WIDTH_CMD;
               fend_in  = 1'b1;
               last_in  = 1'b0;
               if (count_ff[1:0] == 2'd2) begin
                  state_in = BK_HEADER;
                  count_in = '0;
               end else begin
                  count_in = count_ff + NIB_IDX_W'(1);
               end
            end
         end
         BK_HEADER: begin
            if (load) begin
               valid_in = 1'b1;
               word_in  = WRITE_HEADER;
               width_in = WIDTH_HEADER;
               fend_in  = 1'b0;
               last_in  = 1'b0;
               state_in = BK_NIBBLE;
               count_in = '0;
            end
         end
         BK_NIBBLE: begin
            if (load) begin
               valid_in = 1'b1;
               word_in  = WORD_W'(image_ff[count_ff]);
               width_in = WIDTH_NIBBLE;
               fend_in  = nib_end;
               last_in  = nib_end;
               if (nib_end) begin
                  state_in = BK_IDLE;
               end else begin
                  count_in = count_ff + NIB_IDX_W'(1);
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
         for (int n = 0; n < IMAGE_NIBBLES; n++) begin
            image_ff[n] <= 4'h0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         for (int n = 0; n < IMAGE_NIBBLES; n++) begin
            image_ff[n] <= image_in[n];
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      width_ff <= width_in;
      fend_ff  <= fend_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {width_ff, word_ff};
   assign rsp_tuser  = fend_ff;
   assign rsp_tlast  = last_ff;

   a_width_legal: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (width_ff == WIDTH_CMD || width_ff == WIDTH_HEADER ||
                    width_ff == WIDTH_NIBBLE)) else $error("illegal word width");
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff) |-> (fend_ff && width_ff == WIDTH_NIBBLE))
      else $error("last word does not close a frame");
   a_header_word: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && width_ff == WIDTH_HEADER) |-> (word_ff == WRITE_HEADER && !fend_ff))
      else $error("malformed write header");

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top : testbench of the three-line segment LCD readout formatter
// Init and show items go in through a bursty stream driver. An in-bench
// model of the segment image predicts every serial word, and a monitor
// checks each word against it while the result side stalls in changing
// patterns, including two long hold-offs and several full drains of the block.
// ----------------------------------------------------------------------------
module tb_top
   import ltrf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic       OP_SHOW       = 1'b1;
   localparam logic [5:0] MARK_SEG_CODE = 6'h18;
   localparam int         RANDOM_ITEMS  = 450;
   localparam int         CYCLE_LIMIT   = 500000;
   localparam int         HOLD_CYCLES   = 400;

   localparam int RX_FLOW   = 0;
   localparam int RX_RANDOM = 1;
   localparam int RX_SPARSE = 2;

   localparam logic [6:0][5:0] SEG_CODES =
      {6'h12, 6'h22, 6'h24, 6'h28, 6'h14, 6'h11, 6'h21};
   localparam logic [9:0][6:0] DIGIT_GLYPHS =
      {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

   typedef struct {
      logic              op;
      logic [1:0]        line;
      logic [VALUE_W-1:0] value;
      bit                drain;
   } lcd_item_type;

   typedef struct {
      logic [WORD_W-1:0] word;
      logic [BITW_W-1:0] bit_width;
      logic              frame_end;
      logic              last;
   } serial_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // value_milli
   logic [REQ_TUSER_W-1:0] req_tuser = '0;   // operation, line
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // word, bit_width
   logic                   rsp_tuser;        // frame_end
   logic                   rsp_tlast;

   lcd_item_type    lcd_items[$];
   serial_word_type serial_words[$];
   logic [3:0]      lcd_image [IMAGE_NIBBLES];
   int              failures = 0;
   int              cycles = 0;

   lcd_triple_readout_formatter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic add_item(input logic op, input logic [1:0] line,
                           input logic [VALUE_W-1:0] value, input bit drain);
      lcd_item_type it;
      it.op    = op;
      it.line  = line;
      it.value = value;
      it.drain = drain;
      lcd_items.push_back(it);
   endtask

   task automatic push_word(input logic [WORD_W-1:0] word, input logic [BITW_W-1:0] bw,
                            input logic fend, input logic last);
      serial_word_type w;
      w.word      = word;
      w.bit_width = bw;
      w.frame_end = fend;
      w.last      = last;
      serial_words.push_back(w);
   endtask

   task automatic light_segment(input int unsigned digit, input logic [5:0] code,
                                input bit on);
      int unsigned pos;
      pos = 2 * digit + code[5:4];
      if (pos < IMAGE_NIBBLES) begin
         if (on)
            lcd_image[pos] = lcd_image[pos] | code[3:0];
         else
            lcd_image[pos] = lcd_image[pos] & ~code[3:0];
      end
   endtask

   task automatic draw_digit(input int unsigned digit, input int unsigned val);
      for (int i = 0; i < 7; i++)
         light_segment(digit, SEG_CODES[i], DIGIT_GLYPHS[val % 10][i]);
   endtask

   task automatic format_readout(input lcd_item_type it);
      int unsigned d;
      int unsigned v;
      int unsigned r;
      if (it.op == OP_INIT) begin
         push_word(CMD_SYS_EN, WIDTH_CMD, 1'b1, 1'b0);
         push_word(CMD_LCD_ON, WIDTH_CMD, 1'b1, 1'b0);
         push_word(CMD_BIAS, WIDTH_CMD, 1'b1, 1'b0);
         foreach (lcd_image[i]) lcd_image[i] = 4'h0;
         light_segment(0, MARK_SEG_CODE, 1'b1);
         light_segment(3, MARK_SEG_CODE, 1'b1);
         light_segment(6, MARK_SEG_CODE, 1'b1);
      end else begin
         if (it.line == LINE_NONE) return;
         d = it.line * 3;
         v = it.value;
         if (v < LIMIT_HUNDREDTHS) begin
            r = (v + 5) / 10;
            light_segment(d + 1, MARK_SEG_CODE, 1'b0);
            light_segment(d + 2, MARK_SEG_CODE, 1'b1);
         end else if (v < LIMIT_TENTHS) begin
            r = (v + 50) / 100;
            light_segment(d + 1, MARK_SEG_CODE, 1'b1);
            light_segment(d + 2, MARK_SEG_CODE, 1'b0);
         end else begin
            r = (v + 500) / 1000;
            light_segment(d + 1, MARK_SEG_CODE, 1'b0);
            light_segment(d + 2, MARK_SEG_CODE, 1'b0);
         end
         draw_digit(d, r % 10);
         draw_digit(d + 1, (r / 10) % 10);
         draw_digit(d + 2, (r / 100) % 10);
      end
      push_word(WRITE_HEADER, WIDTH_HEADER, 1'b0, 1'b0);
      for (int i = 0; i < IMAGE_NIBBLES; i++)
         push_word({8'h00, lcd_image[i]}, WIDTH_NIBBLE, i == IMAGE_NIBBLES - 1,
                   i == IMAGE_NIBBLES - 1);
   endtask

   initial begin
      foreach (lcd_image[i]) lcd_image[i] = 4'h0;
   end

   // driver
   lcd_item_type held;
   int           burst_left = 0;
   int           gap_left = 0;

   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            format_readout(held);
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (lcd_items.size() != 0 &&
                         !(lcd_items[0].drain && serial_words.size() != 0)) begin
               held  = lcd_items.pop_front();
               offer = 1'b1;
               if (burst_left != 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end
            end
         end
         req_tvalid <= offer;
         req_tdata  <= {{(REQ_TDATA_W - VALUE_W){1'b0}}, held.value};
         req_tuser  <= {held.line, held.op};
      end
   end

   // monitor
   int words_seen = 0;
   int hold_left = 0;
   int rx_mode = RX_FLOW;
   int mode_left = 0;

   always @(posedge clock) begin
      serial_word_type w;
      logic ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (serial_words.size() == 0) begin
               $error("unexpected word: tdata %h tuser %b tlast %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               failures++;
            end else begin
               w = serial_words.pop_front();
               if (rsp_tdata[WORD_W-1:0] !== w.word) begin
                  $error("word: expected %h, actual %h", w.word, rsp_tdata[WORD_W-1:0]);
                  failures++;
               end
               if (rsp_tdata[WORD_W +: BITW_W] !== w.bit_width) begin
                  $error("bit_width: expected %0d, actual %0d", w.bit_width,
                         rsp_tdata[WORD_W +: BITW_W]);
                  failures++;
               end
               if (rsp_tuser !== w.frame_end) begin
                  $error("frame_end: expected %b, actual %b", w.frame_end, rsp_tuser);
                  failures++;
               end
               if (rsp_tlast !== w.last) begin
                  $error("last: expected %b, actual %b", w.last, rsp_tlast);
                  failures++;
               end
            end
            words_seen++;
            if (words_seen == 1500 || words_seen == 6000)
               hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            rx_mode   = $urandom_range(RX_FLOW, RX_SPARSE);
            mode_left = $urandom_range(20, 300);
         end else begin
            mode_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            ready = 1'b0;
         end else begin
            case (rx_mode)
               RX_FLOW:   ready = 1'b1;
               RX_RANDOM: ready = 1'($urandom_range(0, 1));
               default:   ready = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_tready <= ready;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int          kind;
      int          s;
      int          lim;
      logic [19:0] v;

      // show before any init, then init and every rounding regime per line
      add_item(OP_SHOW, 2'd1, 20'd777, 1'b0);
      add_item(OP_INIT, 2'd0, 20'd0, 1'b0);
      add_item(OP_SHOW, 2'd0, 20'd0, 1'b0);
      add_item(OP_SHOW, 2'd1, 20'd5, 1'b0);
      add_item(OP_SHOW, 2'd2, 20'd9994, 1'b0);
      add_item(OP_SHOW, 2'd0, 20'd9995, 1'b0);
      add_item(OP_SHOW, 2'd1, 20'd9999, 1'b0);
      add_item(OP_SHOW, 2'd2, 20'd10000, 1'b0);
      add_item(OP_SHOW, 2'd0, 20'd99949, 1'b0);
      add_item(OP_SHOW, 2'd1, 20'd99950, 1'b0);
      add_item(OP_SHOW, 2'd2, 20'd99999, 1'b0);
      add_item(OP_SHOW, 2'd0, 20'd100000, 1'b0);
      add_item(OP_SHOW, 2'd1, 20'd999499, 1'b0);
      add_item(OP_SHOW, 2'd2, 20'd999500, 1'b0);
      add_item(OP_SHOW, 2'd0, 20'd999999, 1'b0);
      add_item(OP_SHOW, 2'd1, 20'hFFFFF, 1'b0);
      add_item(OP_SHOW, LINE_NONE, 20'hFFFFF, 1'b0);
      add_item(OP_SHOW, 2'd2, 20'd4, 1'b1);
      add_item(OP_INIT, LINE_NONE, 20'hFFFFF, 1'b0);
      add_item(OP_SHOW, 2'd2, 20'd123456, 1'b0);
      add_item(OP_INIT, 2'd2, 20'd0, 1'b0);
      add_item(OP_SHOW, 2'd0, 20'd4, 1'b0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         kind = $urandom_range(0, 99);
         if (kind < 5) begin
            add_item(OP_INIT, 2'($urandom_range(0, 3)),
                     VALUE_W'($urandom_range(0, 20'hFFFFF)), n == 0);
         end else if (kind < 10) begin
            add_item(OP_SHOW, LINE_NONE, VALUE_W'($urandom_range(0, 20'hFFFFF)), n == 0);
         end else begin
            case ($urandom_range(0, 4))
               0: v = 20'($urandom_range(0, 9999));
               1: v = 20'($urandom_range(10000, 99999));
               2: v = 20'($urandom_range(100000, 20'hFFFFF));
               3: begin
                  s   = ($urandom_range(0, 2) == 0) ? 10 : ($urandom_range(0, 1) ? 100 : 1000);
                  lim = (s == 1000) ? 1048 : 999;
                  v   = 20'($urandom_range(0, lim) * s + s / 2 - $urandom_range(0, 1));
               end
               default: v = 20'($urandom_range(0, 999));
            endcase
            add_item(OP_SHOW, 2'($urandom_range(0, 2)), v,
                     n == 0 || $urandom_range(0, 99) < 3);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (lcd_items.size() != 0 || req_tvalid) @(posedge clock);
      while (serial_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
